// ----- rtl/rbd_pkg.sv -----
// Shared types and constants of the RGBA 2x2 box downscaler.
`default_nettype none

package rbd_pkg;

    localparam int PIX_W      = 8;
    localparam int LANE_W     = 9;
    localparam int LANES      = 4;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 12;
    localparam int DIM_CMP_W  = 15;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

    typedef logic [LANES-1:0][LANE_W-1:0] t_lanes;

endpackage

`default_nettype wire

// ----- rtl/rbd_if.sv -----
// Handshake interfaces: pixel in, averaged pixel out, register write.
`default_nettype none

interface rbd_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rbd_pkg::PIX_W-1:0]  red;
    logic [rbd_pkg::PIX_W-1:0]  green;
    logic [rbd_pkg::PIX_W-1:0]  blue;
    logic [rbd_pkg::PIX_W-1:0]  alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rbd_avg_if;
    logic                       valid;
    logic                       ready;
    logic [rbd_pkg::PIX_W-1:0]  avg_red;
    logic [rbd_pkg::PIX_W-1:0]  avg_green;
    logic [rbd_pkg::PIX_W-1:0]  avg_blue;
    logic [rbd_pkg::PIX_W-1:0]  avg_alpha;
    logic                       frame_end;

    modport source (output valid, avg_red, avg_green, avg_blue, avg_alpha, frame_end,
                    input ready);
    modport sink   (input valid, avg_red, avg_green, avg_blue, avg_alpha, frame_end,
                    output ready);
endinterface

interface rbd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbd_pkg::CFG_IDX_W-1:0]  index;
    logic [rbd_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rgba_box_downscale_2x2_core.sv -----
// Top level: 2x2 box-filter downscaler for a raster RGBA pixel stream.
//
//  port    dir  kind        word
//  i_pix   in   valid/ready red, green, blue, alpha (8b each)
//  o_avg   out  valid/ready avg_red..avg_alpha (8b each), frame_end
//  i_cfg   in   valid/ready index (2b), data (13b); always ready
//
//  One pixel word per cycle sustained unless the output stalls. A block's
//  result is registered at the line store read, then at the output register.
//  Even rows write pair sums to the line store, odd rows read them back.
//  Reset restores 640x480 and zeroes the counters; the line store is not cleared.
//  i_pix stalls only when both the read stage and the output word are held.
`default_nettype none

module rgba_box_downscale_2x2_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rbd_pix_if.sink     i_pix,
    rbd_avg_if.source   o_avg,
    rbd_cfg_if.sink     i_cfg
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = CW - 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int LW    = rbd_pkg::LANE_W;
    localparam int PW    = rbd_pkg::PIX_W;
    localparam int DW    = rbd_pkg::DIM_CMP_W;

    logic [rbd_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [CW-1:0]             r_col, n_col;
    logic [rbd_pkg::ROW_W-1:0] r_row, n_row;
    rbd_pkg::t_lanes           r_pair, n_pair, pix, sum;
    rbd_pkg::t_lanes           r_s1_pair, above;
    logic                      r_s1_valid, r_s1_end;
    logic                      r_o_valid;
    logic [PW-1:0]             r_o_r, r_o_g, r_o_b, r_o_a;
    logic                      r_o_end;

    logic [DW-1:0] cfg_w, cfg_h, eff_w, eff_h, even_w, even_h, x_ext, y_ext, x_nxt, y_nxt;
    logic          in_acc, in_ready, out_free, in_range, last, ram_we, ram_re;
    logic [$bits(rbd_pkg::t_lanes)-1:0] ram_q;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= rbd_pkg::RST_IMAGE_WIDTH;
            r_cfg_h <= rbd_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rbd_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg.data;
                rbd_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        cfg_w = DW'(r_cfg_w);
        cfg_h = DW'(r_cfg_h);
        if (cfg_w < DW'(2)) begin
            eff_w = DW'(2);
        end else if (cfg_w > DW'(MAX_WIDTH)) begin
            eff_w = DW'(MAX_WIDTH);
        end else begin
            eff_w = cfg_w;
        end
        if (cfg_h < DW'(2)) begin
            eff_h = DW'(2);
        end else if (cfg_h > DW'(rbd_pkg::MAX_HEIGHT)) begin
            eff_h = DW'(rbd_pkg::MAX_HEIGHT);
        end else begin
            eff_h = cfg_h;
        end
        even_w = {eff_w[DW-1:1], 1'b0};
        even_h = {eff_h[DW-1:1], 1'b0};
    end

    // handshake
    assign out_free    = !r_o_valid || o_avg.ready;
    assign in_ready    = !r_s1_valid || out_free;
    assign i_pix.ready = in_ready;
    assign in_acc      = i_pix.valid && in_ready;

    // position and pair sums
    always_comb begin
        x_ext    = DW'(r_col);
        y_ext    = DW'(r_row);
        x_nxt    = x_ext + DW'(1);
        y_nxt    = y_ext + DW'(1);
        in_range = (x_ext < even_w) && (y_ext < even_h);
        last     = (x_ext == even_w - DW'(1)) && (y_ext == even_h - DW'(1));
        pix[0]   = LW'(i_pix.red);
        pix[1]   = LW'(i_pix.green);
        pix[2]   = LW'(i_pix.blue);
        pix[3]   = LW'(i_pix.alpha);
        for (int k = 0; k < rbd_pkg::LANES; k++) begin
            sum[k] = r_pair[k] + pix[k];
        end
        n_pair = r_col[0] ? sum : pix;
        if (x_nxt >= eff_w) begin
            n_col = '0;
            n_row = (y_nxt >= eff_h) ? '0 : y_nxt[rbd_pkg::ROW_W-1:0];
        end else begin
            n_col = x_nxt[CW-1:0];
            n_row = r_row;
        end
    end

    assign ram_we = in_acc && r_col[0] && in_range && !r_row[0];
    assign ram_re = in_acc && r_col[0] && in_range && r_row[0];

    rbd_ram #(
        .WIDTH ($bits(rbd_pkg::t_lanes)),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col[CW-1:1]),
        .i_wdata (sum),
        .i_re    (ram_re),
        .i_raddr (r_col[AW:1]),
        .o_rdata (ram_q)
    );

    assign above = rbd_pkg::t_lanes'(ram_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_pair     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_pair <= n_pair;
            end
            if (ram_re) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_pair <= sum;
            r_s1_end  <= last;
        end
        if (out_free && r_s1_valid) begin
            r_o_r   <= PW'(10'(above[0] + r_s1_pair[0]) >> 2);
            r_o_g   <= PW'(10'(above[1] + r_s1_pair[1]) >> 2);
            r_o_b   <= PW'(10'(above[2] + r_s1_pair[2]) >> 2);
            r_o_a   <= PW'(10'(above[3] + r_s1_pair[3]) >> 2);
            r_o_end <= r_s1_end;
        end
    end

    assign o_avg.valid     = r_o_valid;
    assign o_avg.avg_red   = r_o_r;
    assign o_avg.avg_green = r_o_g;
    assign o_avg.avg_blue  = r_o_b;
    assign o_avg.avg_alpha = r_o_a;
    assign o_avg.frame_end = r_o_end;

`ifndef SYNTH
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store read and write in one cycle");

    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_s1_valid)
        else $error("read stage lost a block");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_s1_valid && r_o_valid && !o_avg.ready))
        else $error("input stalled without a full pipeline");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_pair) && $stable(ram_q)))
        else $error("held block changed while stalled");
`endif

endmodule

`default_nettype wire
